// File: hdl/texel_format_to_rgba8_defines.svh
// texel_format_to_rgba8_defines.svh: assertion macros for the texel expander checkers
// expects signals named clk and arst_n in the scope where a macro is used
`ifndef TEXEL_FORMAT_TO_RGBA8_DEFINES_SVH
`define TEXEL_FORMAT_TO_RGBA8_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define TFR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tfr_pkg.sv
// tfr_pkg: shared types, codes and expansion helpers for the texel expander
// no dependencies; used by tfr_decode, tfr_pixel_out and the top level through scoped names
`default_nettype none

package tfr_pkg;

	// palette geometry
	localparam int PalEntries = 256;
	localparam int PalAw = $clog2(PalEntries);
	localparam int PalDw = 24;
	localparam logic [8:0] PalDepth = 9'(PalEntries);

	// request codes
	localparam logic ReqConvert  = 1'b0;
	localparam logic ReqPalWrite = 1'b1;

	// configuration register indexes
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 5;
	localparam logic [CfgIdxW-1:0] CfgTexelFormat = 1'b0;
	localparam logic [CfgIdxW-1:0] CfgColorMatrix = 1'b1;

	// texel formats; codes 17..31 are unknown and expand to opaque black
	typedef enum logic [4:0] {
		FmtRgb332   = 5'd0,
		FmtArgb8332 = 5'd1,
		FmtRgb555   = 5'd2,
		FmtRgb565   = 5'd3,
		FmtRgb888   = 5'd4,
		FmtArgb1555 = 5'd5,
		FmtArgb4444 = 5'd6,
		FmtArgb8888 = 5'd7,
		FmtA8       = 5'd8,
		FmtI8       = 5'd9,
		FmtAi44     = 5'd10,
		FmtAi88     = 5'd11,
		FmtP8       = 5'd12,
		FmtAp88     = 5'd13,
		FmtZa16     = 5'd14,
		FmtUyvy     = 5'd15,
		FmtYuyv     = 5'd16
	} fmt_t;

	// one output pixel
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       ha;
	} pix_t;

	// decoded item: direct pixel, or yuv products for two pixels
	typedef struct packed {
		pix_t              pix;
		logic              two;
		logic signed [19:0] py0;
		logic signed [19:0] py1;
		logic signed [19:0] pr;
		logic signed [19:0] pgu;
		logic signed [19:0] pgv;
		logic signed [19:0] pb;
	} conv_t;

	// 3-bit field to 8 bits, v*255/7
	function automatic logic [7:0] x3(input logic [2:0] v);
		logic [7:0] res;
		unique case (v)
			3'd0: res = 8'd0;
			3'd1: res = 8'd36;
			3'd2: res = 8'd72;
			3'd3: res = 8'd109;
			3'd4: res = 8'd145;
			3'd5: res = 8'd182;
			3'd6: res = 8'd218;
			3'd7: res = 8'd255;
			default: res = 8'd0;
		endcase
		return res;
	endfunction

	// 5-bit field to 8 bits, (v*510+31)/62 via reciprocal 16913/2^20
	function automatic logic [7:0] x5(input logic [4:0] v);
		logic [13:0] n;
		logic [28:0] p;
		n = 14'({9'd0, v} * 14'd510) + 14'd31;
		p = 29'(n) * 29'd16913;
		return p[27:20];
	endfunction

	// 6-bit field to 8 bits, (v*510+63)/126 via reciprocal 33289/2^22
	function automatic logic [7:0] x6(input logic [5:0] v);
		logic [14:0] n;
		logic [30:0] p;
		n = 15'({9'd0, v} * 15'd510) + 15'd63;
		p = 31'(n) * 31'd33289;
		return p[29:22];
	endfunction

	// round, floor-shift by 8 and clamp to 0..255
	function automatic logic [7:0] clamp8(input logic signed [19:0] s);
		logic signed [19:0] t;
		logic signed [19:0] q;
		logic [7:0] res;
		t = s + 20'sd128;
		q = t >>> 8;
		if (q < 20'sd0) begin
			res = 8'd0;
		end else if (q > 20'sd255) begin
			res = 8'hff;
		end else begin
			res = q[7:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: hdl/tfr_pal_ram.sv
// tfr_pal_ram: generic single-write, single-read synchronous ram, registered read data
// no dependencies
`default_nettype none

module tfr_pal_ram #(
	parameter int Depth = 256,
	parameter int Aw = 8,
	parameter int Dw = 24
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [Aw-1:0] waddr,
	input  wire logic [Dw-1:0] wdata,
	input  wire logic          re,
	input  wire logic [Aw-1:0] raddr,
	output      logic [Dw-1:0] rdata
);

	logic [Dw-1:0] mem [Depth];
	logic [Dw-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data, loaded when re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hdl/tfr_decode.sv
// tfr_decode: unpacks one texel word into a pixel or into yuv products for two pixels
// depends on tfr_pkg
`default_nettype none

module tfr_decode (
	input  wire logic [31:0]          word,
	input  wire tfr_pkg::fmt_t        fmt,
	input  wire logic                 alt,
	input  wire logic [23:0]          pal_data,
	input  wire logic                 pal_oob,
	output      tfr_pkg::conv_t       conv
);

	logic [7:0] b0, b1, b2, b3;
	logic [23:0] pal;
	logic [7:0] y0, y1, u, v;
	logic signed [19:0] c0, c1, d, e;
	logic signed [19:0] kr, kgu, kgv, kb;

	assign b0 = word[7:0];
	assign b1 = word[15:8];
	assign b2 = word[23:16];
	assign b3 = word[31:24];

	// out-of-range palette index reads as black
	assign pal = pal_oob ? '0 : pal_data;

	// yuv byte order
	always_comb begin
		if (fmt == tfr_pkg::FmtYuyv) begin
			y0 = b0;
			u  = b1;
			y1 = b2;
			v  = b3;
		end else begin
			u  = b0;
			y0 = b1;
			v  = b2;
			y1 = b3;
		end
	end

	// centered yuv terms and coefficient set
	assign c0 = $signed({12'd0, y0}) - 20'sd16;
	assign c1 = $signed({12'd0, y1}) - 20'sd16;
	assign d  = $signed({12'd0, u}) - 20'sd128;
	assign e  = $signed({12'd0, v}) - 20'sd128;
	assign kr  = alt ? 20'sd459 : 20'sd409;
	assign kgu = alt ? 20'sd55  : 20'sd100;
	assign kgv = alt ? 20'sd136 : 20'sd208;
	assign kb  = alt ? 20'sd541 : 20'sd516;

	// per-format expansion and yuv products
	always_comb begin
		conv.pix.r  = 8'd0;
		conv.pix.g  = 8'd0;
		conv.pix.b  = 8'd0;
		conv.pix.a  = 8'hff;
		conv.pix.ha = 1'b0;
		conv.two = (fmt == tfr_pkg::FmtUyvy) || (fmt == tfr_pkg::FmtYuyv);
		conv.py0 = c0 * 20'sd298;
		conv.py1 = c1 * 20'sd298;
		conv.pr  = kr * e;
		conv.pgu = kgu * d;
		conv.pgv = kgv * e;
		conv.pb  = kb * d;
		unique case (fmt)
			tfr_pkg::FmtRgb332: begin
				conv.pix.r = tfr_pkg::x3(b0[7:5]);
				conv.pix.g = tfr_pkg::x3(b0[4:2]);
				conv.pix.b = {4{b0[1:0]}};
			end
			tfr_pkg::FmtArgb8332: begin
				conv.pix.r  = tfr_pkg::x3(b0[7:5]);
				conv.pix.g  = tfr_pkg::x3(b0[4:2]);
				conv.pix.b  = {4{b0[1:0]}};
				conv.pix.a  = b1;
				conv.pix.ha = 1'b1;
			end
			tfr_pkg::FmtRgb555: begin
				conv.pix.r = tfr_pkg::x5(word[14:10]);
				conv.pix.g = tfr_pkg::x5(word[9:5]);
				conv.pix.b = tfr_pkg::x5(word[4:0]);
			end
			tfr_pkg::FmtRgb565: begin
				conv.pix.r = tfr_pkg::x5(word[15:11]);
				conv.pix.g = tfr_pkg::x6(word[10:5]);
				conv.pix.b = tfr_pkg::x5(word[4:0]);
			end
			tfr_pkg::FmtRgb888: begin
				conv.pix.r = b0;
				conv.pix.g = b1;
				conv.pix.b = b2;
			end
			tfr_pkg::FmtArgb1555: begin
				conv.pix.r  = tfr_pkg::x5(word[14:10]);
				conv.pix.g  = tfr_pkg::x5(word[9:5]);
				conv.pix.b  = tfr_pkg::x5(word[4:0]);
				conv.pix.a  = {8{word[15]}};
				conv.pix.ha = 1'b1;
			end
			tfr_pkg::FmtArgb4444: begin
				conv.pix.a  = {2{word[15:12]}};
				conv.pix.r  = {2{word[11:8]}};
				conv.pix.g  = {2{word[7:4]}};
				conv.pix.b  = {2{word[3:0]}};
				conv.pix.ha = 1'b1;
			end
			tfr_pkg::FmtArgb8888: begin
				conv.pix.r  = b2;
				conv.pix.g  = b1;
				conv.pix.b  = b0;
				conv.pix.a  = b3;
				conv.pix.ha = 1'b1;
			end
			tfr_pkg::FmtA8: begin
				conv.pix.r  = 8'hff;
				conv.pix.g  = 8'hff;
				conv.pix.b  = 8'hff;
				conv.pix.a  = b0;
				conv.pix.ha = 1'b1;
			end
			tfr_pkg::FmtI8: begin
				conv.pix.r  = b0;
				conv.pix.g  = b0;
				conv.pix.b  = b0;
				conv.pix.ha = 1'b1;
			end
			tfr_pkg::FmtAi44: begin
				conv.pix.r  = {2{b0[3:0]}};
				conv.pix.g  = {2{b0[3:0]}};
				conv.pix.b  = {2{b0[3:0]}};
				conv.pix.a  = {2{b0[7:4]}};
				conv.pix.ha = 1'b1;
			end
			tfr_pkg::FmtAi88, tfr_pkg::FmtZa16: begin
				conv.pix.r  = b0;
				conv.pix.g  = b0;
				conv.pix.b  = b0;
				conv.pix.a  = b1;
				conv.pix.ha = 1'b1;
			end
			tfr_pkg::FmtP8: begin
				conv.pix.r = pal[23:16];
				conv.pix.g = pal[15:8];
				conv.pix.b = pal[7:0];
			end
			tfr_pkg::FmtAp88: begin
				conv.pix.r  = pal[23:16];
				conv.pix.g  = pal[15:8];
				conv.pix.b  = pal[7:0];
				conv.pix.a  = b1;
				conv.pix.ha = 1'b1;
			end
			tfr_pkg::FmtUyvy, tfr_pkg::FmtYuyv: begin
				conv.pix.a = 8'hff;
			end
			default: begin
				conv.pix.a = 8'hff;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/tfr_pixel_out.sv
// tfr_pixel_out: sums yuv products for the selected pixel and clamps, or passes a direct pixel
// depends on tfr_pkg
`default_nettype none

module tfr_pixel_out (
	input  wire tfr_pkg::conv_t conv,
	input  wire logic           phase,
	output      tfr_pkg::pix_t  pix,
	output      logic           last
);

	logic signed [19:0] py;
	logic signed [19:0] sum_r, sum_g, sum_b;

	// luma term of the pixel in flight
	assign py = phase ? conv.py1 : conv.py0;

	assign sum_r = py + conv.pr;
	assign sum_g = py - conv.pgu - conv.pgv;
	assign sum_b = py + conv.pb;

	// select yuv result or the direct pixel
	always_comb begin
		if (conv.two) begin
			pix.r  = tfr_pkg::clamp8(sum_r);
			pix.g  = tfr_pkg::clamp8(sum_g);
			pix.b  = tfr_pkg::clamp8(sum_b);
			pix.a  = 8'hff;
			pix.ha = 1'b0;
			last   = phase;
		end else begin
			pix  = conv.pix;
			last = 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: hdl/texel_format_to_rgba8.sv
// texel_format_to_rgba8: Expands one little-endian texel word per item to 8-bit RGBA.
//
// Input channel (in_valid/in_stall): req_type 0 converts source_word in the current
// texel_format; req_type 1 writes source_word[23:0] to palette entry palette_index and
// yields no result. Output channel (out_valid/out_stall) gives red, green, blue, alpha,
// has_alpha and last. The config channel (cfg_valid/cfg_ready, always ready) writes
// texel_format (index 0) and color_matrix (index 1); the user must write them only
// while the block is idle; the block does not enforce it. A word passes the palette
// read stage, the decode stage and the output register. Throughput: one word per cycle
// for one-pixel formats when out_stall is low; uyvy and yuyv give two results per word,
// and stage 2 holds such a word until its second result loads. A palette write followed
// at once by a read of the same entry sees the new color, since the ram write lands
// before the next read edge. Reset: texel_format rgb565, color_matrix BT.601, pipeline
// empty; palette contents are undefined until written. When the receiver stalls, the
// output register holds its item, the two pipeline stages fill, then in_stall rises.
// depends on tfr_pkg, tfr_pal_ram, tfr_decode, tfr_pixel_out
`default_nettype none

module texel_format_to_rgba8 (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input items
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic                          req_type,
	input  wire logic [31:0]                   source_word,
	input  wire logic [7:0]                    palette_index,
	// result items
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [7:0]                    red,
	output      logic [7:0]                    green,
	output      logic [7:0]                    blue,
	output      logic [7:0]                    alpha,
	output      logic                          has_alpha,
	output      logic                          last,
	// configuration writes
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [tfr_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [tfr_pkg::CfgDataW-1:0]  cfg_data
);

	tfr_pkg::fmt_t texel_format_q;
	logic          color_matrix_q;

	logic accept, accept_conv, pal_we, rd_oob;
	logic s1_free, s1_move, s2_free, s2_release, out_load;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        oob_s1;
	logic [tfr_pkg::PalDw-1:0] pal_rdata;

	logic           valid_s2;
	tfr_pkg::conv_t conv_s2;
	tfr_pkg::conv_t conv_d;
	logic           phase_q;

	tfr_pkg::pix_t pix_d;
	logic          last_d;
	tfr_pkg::pix_t out_pix_q;
	logic          out_last_q;
	logic          out_valid_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texel_format_q <= tfr_pkg::FmtRgb565;
			color_matrix_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tfr_pkg::CfgTexelFormat: texel_format_q <= tfr_pkg::fmt_t'(cfg_data);
				tfr_pkg::CfgColorMatrix: color_matrix_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake and flow control
	assign accept      = in_valid && !in_stall;
	assign accept_conv = accept && (req_type == tfr_pkg::ReqConvert);
	assign out_load    = valid_s2 && (!out_valid_q || !out_stall);
	assign s2_release  = out_load && (!conv_s2.two || phase_q);
	assign s2_free     = !valid_s2 || s2_release;
	assign s1_move     = valid_s1 && s2_free;
	assign s1_free     = !valid_s1 || s1_move;
	assign in_stall    = !s1_free;

	// palette port: writes at accept, reads issued at accept of a convert item
	assign rd_oob = {1'b0, source_word[7:0]} >= tfr_pkg::PalDepth;
	assign pal_we = accept && (req_type == tfr_pkg::ReqPalWrite) &&
		({1'b0, palette_index} < tfr_pkg::PalDepth);

	tfr_pal_ram #(
		.Depth (tfr_pkg::PalEntries),
		.Aw    (tfr_pkg::PalAw),
		.Dw    (tfr_pkg::PalDw)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (palette_index[tfr_pkg::PalAw-1:0]),
		.wdata (source_word[tfr_pkg::PalDw-1:0]),
		.re    (accept_conv),
		.raddr (source_word[tfr_pkg::PalAw-1:0]),
		.rdata (pal_rdata)
	);

	// stage 1: word alongside palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept_conv;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_conv) begin
			word_s1 <= source_word;
			oob_s1  <= rd_oob;
		end
	end

	// decode of the stage 1 word
	tfr_decode u_decode (
		.word     (word_s1),
		.fmt      (texel_format_q),
		.alt      (color_matrix_q),
		.pal_data (pal_rdata),
		.pal_oob  (oob_s1),
		.conv     (conv_d)
	);

	// stage 2: decoded item, held on yuv formats until its second pixel is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_load) begin
				phase_q <= conv_s2.two && !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			conv_s2 <= conv_d;
		end
	end

	tfr_pixel_out u_pixel_out (
		.conv  (conv_s2),
		.phase (phase_q),
		.pix   (pix_d),
		.last  (last_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q  <= pix_d;
			out_last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = out_pix_q.r;
	assign green     = out_pix_q.g;
	assign blue      = out_pix_q.b;
	assign alpha     = out_pix_q.a;
	assign has_alpha = out_pix_q.ha;
	assign last      = out_last_q;

endmodule

`default_nettype wire

// File: hdl/tfr_port_check.sv
// tfr_port_check: port-level checks on the result channel of texel_format_to_rgba8
// depends on texel_format_to_rgba8_defines.svh; bound to the top level below
`default_nettype none
`include "texel_format_to_rgba8_defines.svh"

module tfr_port_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic [7:0] alpha,
	input wire logic       has_alpha,
	input wire logic       last
);

	logic [33:0] res_bits;
	logic        out_take;

	// result payload as one vector, and the result handshake
	assign res_bits = {red, green, blue, alpha, has_alpha, last};
	assign out_take = out_valid && !out_stall;

	// a stalled result stays offered
	`TFR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	// a stalled result keeps its payload
	`TFR_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(res_bits), "stalled result changed")

	// three-channel results are opaque
	`TFR_ASSERT_IMP(a_opaque, out_valid && !has_alpha, alpha == 8'hff, "alpha not 255")

	// the first pixel of a word pair is followed at once by the second
	`TFR_ASSERT_NXT(a_pair_next, out_take && !last, out_valid && last, "second pixel late")

endmodule

bind texel_format_to_rgba8 tfr_port_check u_port_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.red       (red),
	.green     (green),
	.blue      (blue),
	.alpha     (alpha),
	.has_alpha (has_alpha),
	.last      (last)
);

`default_nettype wire

// File: verif/texel_format_to_rgba8_test.sv
// texel_format_to_rgba8_test: self-checking bench for the texel word to rgba8 expander
// a predictor class tracks formats, yuv coefficients and palette contents
// depends on tfr_pkg and texel_format_to_rgba8
`default_nettype none

module texel_format_to_rgba8_test;

	localparam int IdleLimit = 1000;
	localparam int DrainCycles = 4;
	localparam int RandomWords = 1550;

	// one expanded pixel as it leaves the block
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       ha;
		logic       last;
	} rgba_pixel_t;

	// predicted pixels, held in arrival order
	class rgba_expansion;
		logic [4:0]  fmt_code;
		logic        matrix_alt;
		logic [23:0] palette [256];
		rgba_pixel_t pending_pixels[$];
		int          errors;
		int          checked;
		int          pal_writes;

		function new();
			fmt_code = tfr_pkg::FmtRgb565;
			matrix_alt = 1'b0;
			errors = 0;
			checked = 0;
			pal_writes = 0;
		endfunction

		function void set_register(logic [tfr_pkg::CfgIdxW-1:0] idx,
				logic [tfr_pkg::CfgDataW-1:0] data);
			if (idx == tfr_pkg::CfgTexelFormat) begin
				fmt_code = data[4:0];
			end else begin
				matrix_alt = data[0];
			end
		endfunction

		// field widening; 5- and 6-bit fields with rounding, 3-bit fields rounded down
		function logic [7:0] widen3(logic [2:0] v);
			return 8'(int'(v) * 255 / 7);
		endfunction

		function logic [7:0] widen4(logic [3:0] v);
			return 8'(int'(v) * 17);
		endfunction

		function logic [7:0] widen5(logic [4:0] v);
			return 8'((int'(v) * 510 + 31) / 62);
		endfunction

		function logic [7:0] widen6(logic [5:0] v);
			return 8'((int'(v) * 510 + 63) / 126);
		endfunction

		// round, floor shift by 8, clamp to a byte
		function logic [7:0] round_clamp(int sum);
			int q;
			q = (sum + 128) >>> 8;
			if (q < 0) begin
				return 8'd0;
			end else if (q > 255) begin
				return 8'hff;
			end
			return 8'(q);
		endfunction

		function rgba_pixel_t yuv_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v,
				logic fin);
			int c, d, e, kr, kgu, kgv, kb;
			rgba_pixel_t p;
			c = int'(y) - 16;
			d = int'(u) - 128;
			e = int'(v) - 128;
			kr = matrix_alt ? 459 : 409;
			kgu = matrix_alt ? 55 : 100;
			kgv = matrix_alt ? 136 : 208;
			kb = matrix_alt ? 541 : 516;
			p.r = round_clamp(298 * c + kr * e);
			p.g = round_clamp(298 * c - kgu * d - kgv * e);
			p.b = round_clamp(298 * c + kb * d);
			p.a = 8'hff;
			p.ha = 1'b0;
			p.last = fin;
			return p;
		endfunction

		// accepted input item: load the palette or queue its pixels
		function void note_word(logic req, logic [31:0] word, logic [7:0] idx);
			logic [7:0] b0, b1, b2, b3;
			logic [23:0] entry;
			rgba_pixel_t p;
			if (req == tfr_pkg::ReqPalWrite) begin
				palette[idx] = word[23:0];
				pal_writes++;
				return;
			end
			b0 = word[7:0];
			b1 = word[15:8];
			b2 = word[23:16];
			b3 = word[31:24];
			p = '{8'd0, 8'd0, 8'd0, 8'hff, 1'b0, 1'b1};
			case (fmt_code)
				tfr_pkg::FmtRgb332, tfr_pkg::FmtArgb8332: begin
					p.r = widen3(b0[7:5]);
					p.g = widen3(b0[4:2]);
					p.b = 8'(int'(b0[1:0]) * 85);
					if (fmt_code == tfr_pkg::FmtArgb8332) begin
						p.a = b1;
						p.ha = 1'b1;
					end
				end
				tfr_pkg::FmtRgb555, tfr_pkg::FmtArgb1555: begin
					p.r = widen5(word[14:10]);
					p.g = widen5(word[9:5]);
					p.b = widen5(word[4:0]);
					if (fmt_code == tfr_pkg::FmtArgb1555) begin
						p.a = word[15] ? 8'hff : 8'h00;
						p.ha = 1'b1;
					end
				end
				tfr_pkg::FmtRgb565: begin
					p.r = widen5(word[15:11]);
					p.g = widen6(word[10:5]);
					p.b = widen5(word[4:0]);
				end
				tfr_pkg::FmtRgb888: begin
					p.r = b0;
					p.g = b1;
					p.b = b2;
				end
				tfr_pkg::FmtArgb4444: begin
					p.a = widen4(word[15:12]);
					p.r = widen4(word[11:8]);
					p.g = widen4(word[7:4]);
					p.b = widen4(word[3:0]);
					p.ha = 1'b1;
				end
				tfr_pkg::FmtArgb8888: begin
					p.r = b2;
					p.g = b1;
					p.b = b0;
					p.a = b3;
					p.ha = 1'b1;
				end
				tfr_pkg::FmtA8: begin
					p.r = 8'hff;
					p.g = 8'hff;
					p.b = 8'hff;
					p.a = b0;
					p.ha = 1'b1;
				end
				tfr_pkg::FmtI8: begin
					p.r = b0;
					p.g = b0;
					p.b = b0;
					p.ha = 1'b1;
				end
				tfr_pkg::FmtAi44: begin
					p.r = widen4(b0[3:0]);
					p.g = p.r;
					p.b = p.r;
					p.a = widen4(b0[7:4]);
					p.ha = 1'b1;
				end
				tfr_pkg::FmtAi88, tfr_pkg::FmtZa16: begin
					p.r = b0;
					p.g = b0;
					p.b = b0;
					p.a = b1;
					p.ha = 1'b1;
				end
				tfr_pkg::FmtP8, tfr_pkg::FmtAp88: begin
					entry = palette[b0];
					p.r = entry[23:16];
					p.g = entry[15:8];
					p.b = entry[7:0];
					if (fmt_code == tfr_pkg::FmtAp88) begin
						p.a = b1;
						p.ha = 1'b1;
					end
				end
				// two pixels share one chroma pair
				tfr_pkg::FmtUyvy: begin
					pending_pixels.push_back(yuv_pixel(b1, b0, b2, 1'b0));
					pending_pixels.push_back(yuv_pixel(b3, b0, b2, 1'b1));
					return;
				end
				tfr_pkg::FmtYuyv: begin
					pending_pixels.push_back(yuv_pixel(b0, b1, b3, 1'b0));
					pending_pixels.push_back(yuv_pixel(b2, b1, b3, 1'b1));
					return;
				end
				// unknown codes give opaque black
				default: begin
				end
			endcase
			pending_pixels.push_back(p);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// accepted result item against the oldest prediction
		function void check_pixel(rgba_pixel_t got);
			rgba_pixel_t want;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d", $time,
					got.r, got.g, got.b, got.a);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			checked++;
			compare_field("red", want.r, got.r);
			compare_field("green", want.g, got.g);
			compare_field("blue", want.b, got.b);
			compare_field("alpha", want.a, got.a);
			compare_field("has_alpha", {7'd0, want.ha}, {7'd0, got.ha});
			compare_field("last", {7'd0, want.last}, {7'd0, got.last});
		endfunction

		function void report_leftover();
			if (pending_pixels.size() != 0) begin
				$display("%0t: %0d predicted pixels never arrived", $time,
					pending_pixels.size());
				errors += pending_pixels.size();
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = tfr_pkg::ReqConvert;
	logic [31:0] source_word = '0;
	logic [7:0] palette_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] red, green, blue, alpha;
	logic has_alpha, last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tfr_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [tfr_pkg::CfgDataW-1:0] cfg_data = '0;

	rgba_expansion predicted;
	bit steady_flow = 1'b0;
	bit pal_loaded [256];
	int loaded_list[$];
	int words_sent = 0;
	int settings_applied = 0;
	int out_hold = 0;
	int idle_cycles = 0;

	texel_format_to_rgba8 dut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	// drive one item, wait for it to be taken, then maybe idle
	task automatic send_item(logic req, logic [31:0] word, logic [7:0] idx);
		int gap;
		in_valid <= 1'b1;
		req_type <= req;
		source_word <= word;
		palette_index <= idx;
		do @(posedge clk); while (in_stall !== 1'b0);
		predicted.note_word(req, word, idx);
		words_sent++;
		if (req == tfr_pkg::ReqPalWrite && !pal_loaded[idx]) begin
			pal_loaded[idx] = 1'b1;
			loaded_list.push_back(int'(idx));
		end
		@(negedge clk);
		gap = steady_flow ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// hold off the sender until every predicted pixel is out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (predicted.pending_pixels.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_reg(logic [tfr_pkg::CfgIdxW-1:0] idx,
			logic [tfr_pkg::CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		predicted.set_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(logic [4:0] fmt, logic alt);
		logic [tfr_pkg::CfgDataW-1:0] mdata;
		mdata = tfr_pkg::CfgDataW'($urandom);
		mdata[0] = alt;
		drain_results();
		write_reg(tfr_pkg::CfgTexelFormat, tfr_pkg::CfgDataW'(fmt));
		write_reg(tfr_pkg::CfgColorMatrix, mdata);
		settings_applied++;
	endtask

	// random item; paletted formats only read loaded entries
	task automatic send_random_word();
		logic [31:0] word;
		int roll;
		word = $urandom;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			word = '0;
		end else if (roll < 10) begin
			word = '1;
		end
		if (loaded_list.size() == 0 || $urandom_range(0, 99) < 15) begin
			send_item(tfr_pkg::ReqPalWrite, word, 8'($urandom));
		end else begin
			if (predicted.fmt_code == tfr_pkg::FmtP8 ||
					predicted.fmt_code == tfr_pkg::FmtAp88) begin
				word[7:0] = 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
			end
			send_item(tfr_pkg::ReqConvert, word, 8'($urandom));
		end
	endtask

	// result receiver stalls
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (out_hold > 0) begin
				out_hold--;
			end else if (steady_flow || out_stall) begin
				out_stall <= 1'b0;
				out_hold = steady_flow ? 0 : gap_len();
			end else begin
				out_stall <= 1'b1;
				out_hold = gap_len();
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			predicted.check_pixel('{red, green, blue, alpha, has_alpha, last});
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t: no handshake for %0d cycles", $time, IdleLimit);
				$display("texel_format_to_rgba8_test NOT OK");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int phase;
		logic [4:0] fmt;
		logic alt;
		predicted = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset format is rgb565
		send_item(tfr_pkg::ReqConvert, 32'h0000_0000, 8'h00);
		send_item(tfr_pkg::ReqConvert, 32'hffff_ffff, 8'hff);
		// palette loads at both ends of the index range
		send_item(tfr_pkg::ReqPalWrite, 32'hffff_ffff, 8'h00);
		send_item(tfr_pkg::ReqPalWrite, 32'h0000_0000, 8'hff);
		send_item(tfr_pkg::ReqPalWrite, 32'h5a3c_a5c3, 8'h80);

		apply_setting(tfr_pkg::FmtP8, 1'b0);
		send_item(tfr_pkg::ReqConvert, 32'hffff_ff00, 8'h00);
		send_item(tfr_pkg::ReqConvert, 32'h0000_00ff, 8'hff);
		send_item(tfr_pkg::ReqConvert, 32'h1234_5680, 8'h80);
		apply_setting(tfr_pkg::FmtAp88, 1'b0);
		send_item(tfr_pkg::ReqConvert, 32'h0000_ff80, 8'h00);

		// yuv extremes and neutral chroma, both coefficient sets
		apply_setting(tfr_pkg::FmtUyvy, 1'b0);
		send_item(tfr_pkg::ReqConvert, 32'h0000_0000, 8'h00);
		send_item(tfr_pkg::ReqConvert, 32'hffff_ffff, 8'h00);
		send_item(tfr_pkg::ReqConvert, 32'heb80_1080, 8'h00);
		apply_setting(tfr_pkg::FmtYuyv, 1'b1);
		send_item(tfr_pkg::ReqConvert, 32'h0000_0000, 8'h00);
		send_item(tfr_pkg::ReqConvert, 32'hffff_ffff, 8'h00);
		send_item(tfr_pkg::ReqConvert, 32'h80eb_8010, 8'h00);

		// unknown format code, 332 and the 1555 alpha bit
		apply_setting(5'd31, 1'b0);
		send_item(tfr_pkg::ReqConvert, 32'h1234_5678, 8'h00);
		apply_setting(tfr_pkg::FmtRgb332, 1'b0);
		send_item(tfr_pkg::ReqConvert, 32'h0000_00ff, 8'h00);
		apply_setting(tfr_pkg::FmtArgb1555, 1'b0);
		send_item(tfr_pkg::ReqConvert, 32'h0000_8000, 8'h00);
		send_item(tfr_pkg::ReqConvert, 32'h0000_7fff, 8'h00);
		// red field of 555 sits in bits 14..10
		apply_setting(tfr_pkg::FmtRgb555, 1'b0);
		send_item(tfr_pkg::ReqConvert, 32'h0000_7c00, 8'h00);

		// random phases: every known format first, then random settings
		phase = 0;
		while (words_sent < RandomWords + 20) begin
			if (phase < 17) begin
				fmt = 5'(phase);
				alt = phase[0];
			end else begin
				fmt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31)) :
					5'($urandom_range(0, 16));
				alt = 1'($urandom_range(0, 1));
			end
			steady_flow = ($urandom_range(0, 3) == 0);
			apply_setting(fmt, alt);
			repeat ($urandom_range(30, 80)) begin
				send_random_word();
				if ($urandom_range(0, 199) == 0) begin
					drain_results();
				end
			end
			phase++;
		end

		// wind down
		drain_results();
		repeat (8) @(negedge clk);
		predicted.report_leftover();
		$display("run covered %0d words, %0d of them palette loads, over %0d settings",
			words_sent, predicted.pal_writes, settings_applied);
		$display("%0d pixels compared field by field, %0d errors",
			predicted.checked, predicted.errors);
		if (predicted.errors == 0) begin
			$display("texel_format_to_rgba8_test OK");
		end else begin
			$display("texel_format_to_rgba8_test NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
